// File: sv/ctsvf_pkg.sv
// Shared types, constants and arithmetic helpers for the cascaded TPT state-variable filter.
// No dependencies; imported by every module of the block.
package ctsvf_pkg;

	localparam int ACC_W      = 32;            // integrator and internal signal width
	localparam int COEF_SHIFT = 20;            // coefficient fraction bits
	localparam int G_W        = 24;
	localparam int R_W        = 24;
	localparam int H_W        = 21;
	localparam int SC_W       = 4;
	localparam int K_W        = R_W + 2;       // 2R + g
	localparam int PROD_W     = K_W + 1 + ACC_W;
	localparam int RND_W      = PROD_W - COEF_SHIFT;
	localparam int SUM_W      = RND_W + 2;
	localparam int STG_CNT_W  = SC_W + 1;
	localparam int APB_AW     = 5;
	localparam int APB_DW     = 32;

	localparam logic [G_W-1:0] G_RESET  = 24'd1048576;
	localparam logic [R_W-1:0] R_RESET  = 24'd1048576;
	localparam logic [H_W-1:0] H_RESET  = 21'd349525;
	localparam logic [SC_W-1:0] SC_RESET = 4'd1;

	localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(2 ** (COEF_SHIFT - 1));

	typedef enum logic [2:0] {
		REG_CUTOFF   = 3'd0,
		REG_DAMPING  = 3'd1,
		REG_NORM     = 3'd2,
		REG_RESPONSE = 3'd3,
		REG_STAGES   = 3'd4,
		REG_VARIANT  = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		RESP_LP    = 2'd0,
		RESP_BP    = 2'd1,
		RESP_HP    = 2'd2,
		RESP_NOTCH = 2'd3
	} resp_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_READ,
		OP_MUL_KS1,
		OP_DIFF,
		OP_MUL_HD,
		OP_HP,
		OP_MUL_GHP,
		OP_BP,
		OP_MUL_GBP,
		OP_LP,
		OP_N2,
		OP_CLIP,
		OP_WRITE,
		OP_FINAL
	} dp_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_MKS,
		ST_DIFF,
		ST_MHD,
		ST_HP,
		ST_MGHP,
		ST_BP,
		ST_MGBP,
		ST_LP,
		ST_N2,
		ST_CLIP,
		ST_DIVW,
		ST_WRITE,
		ST_FINAL
	} ctrl_state_t;

	typedef struct packed {
		logic no_stages;
		logic last_stage;
		logic clip_on;
		logic div_done;
	} dp_sts_t;

	// unsigned coefficient times signed signal
	function automatic logic signed [PROD_W-1:0] coef_mul(input logic [K_W-1:0] coef,
		input logic signed [ACC_W-1:0] sig);
		logic signed [PROD_W-1:0] a;
		logic signed [PROD_W-1:0] b;
		a = signed'({{(PROD_W-K_W){1'b0}}, coef});
		b = {{(PROD_W-ACC_W){sig[ACC_W-1]}}, sig};
		return a * b;
	endfunction

	// shift right by COEF_SHIFT, round half up
	function automatic logic signed [RND_W-1:0] round_coef(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + RND_HALF;
		return t[PROD_W-1:COEF_SHIFT];
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
		logic fits;
		fits = (&v[SUM_W-1:ACC_W-1]) || !(|v[SUM_W-1:ACC_W-1]);
		if (fits)
			return v[ACC_W-1:0];
		else if (v[SUM_W-1])
			return {1'b1, {(ACC_W-1){1'b0}}};
		else
			return {1'b0, {(ACC_W-1){1'b1}}};
	endfunction

endpackage

// File: sv/ctsvf_div.sv
// Sequential soft-clip unit: v * 2^F / (2^F + floor(5|v|/2)), one quotient bit per cycle.
// Depends on ctsvf_pkg.
module ctsvf_div #(
	parameter int FRAC_W = 23
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [ctsvf_pkg::ACC_W-1:0] value,
	output logic                              done,
	output logic signed [ctsvf_pkg::ACC_W-1:0] result
);
	import ctsvf_pkg::*;

	localparam int MAG_W = ACC_W + 1;
	localparam int DEN_W = ACC_W + 4;
	localparam int CNT_W = $clog2(FRAC_W + 2);
	localparam logic [DEN_W-1:0] ONE = DEN_W'(1) << FRAC_W;
	localparam logic [CNT_W-1:0] CNT_SETUP = CNT_W'(FRAC_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [FRAC_W-1:0] quo_q;

	logic [MAG_W-1:0] mag;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   den_ext;
	logic             fit;

	assign mag     = value[ACC_W-1] ? MAG_W'(MAG_W'(0) - MAG_W'(value)) : MAG_W'(value);
	assign rem_sh  = {rem_q, 1'b0};
	assign den_ext = {1'b0, den_q};
	assign fit     = rem_sh >= den_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_SETUP;
		end else if (busy_q && cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(mag);
			neg_q <= value[ACC_W-1];
		end else if (busy_q && cnt_q == CNT_SETUP) begin
			// first busy cycle: rem_q still holds |v|
			den_q <= ONE + (((rem_q << 2) + rem_q) >> 1);
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= fit ? DEN_W'(rem_sh - den_ext) : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[FRAC_W-2:0], fit};
		end
	end

	assign done   = busy_q && (cnt_q == '0);
	assign result = neg_q ? ACC_W'(ACC_W'(0) - ACC_W'(quo_q)) : ACC_W'(quo_q);

endmodule

// File: sv/ctsvf_dp.sv
// Datapath: integrator memories, shared coefficient multiplier, saturation and output register.
// Depends on ctsvf_pkg and ctsvf_div.
module ctsvf_dp #(
	parameter int MAX_STAGES  = 8,
	parameter int CHANNELS    = 2,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ctsvf_pkg::dp_op_t                 op,
	output ctsvf_pkg::dp_sts_t                sts,
	input  logic [ctsvf_pkg::G_W-1:0]          cutoff_gain,
	input  logic [ctsvf_pkg::R_W-1:0]          damping,
	input  logic [ctsvf_pkg::H_W-1:0]          normalizer,
	input  ctsvf_pkg::resp_t                  response_type,
	input  logic [ctsvf_pkg::SC_W-1:0]         stage_count,
	input  logic                              variant,
	input  logic                              channel_index,
	input  logic signed [SAMPLE_BITS-1:0]     sample_in,
	output logic signed [SAMPLE_BITS-1:0]     sample_out
);
	import ctsvf_pkg::*;

	localparam int DEPTH  = MAX_STAGES * CHANNELS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int STG_W  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int FRAC_W = SAMPLE_BITS - 1;
	localparam int FIN_W  = ACC_W + 2;

	logic signed [ACC_W-1:0] mem1 [DEPTH];
	logic signed [ACC_W-1:0] mem2 [DEPTH];
	logic [DEPTH-1:0]        vld_q;

	logic [STG_W-1:0]         stage_q;
	logic [CH_W-1:0]          ch_q;
	logic signed [ACC_W-1:0]  x_q;
	logic signed [ACC_W-1:0]  rd1_q, rd2_q;
	logic                     rdv_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  diff_q, hp_q, bp_q, lp_q, n1_q, n2_q;
	logic signed [RND_W-1:0]  ghp_q, gbp_q;
	logic signed [SAMPLE_BITS-1:0] out_q;

	logic [CH_W-1:0]          ch_sel;
	logic [ADDR_W-1:0]        addr;
	logic [K_W-1:0]           k_coef;
	logic [K_W-1:0]           coef_op;
	logic signed [ACC_W-1:0]  sig_op;
	logic signed [ACC_W-1:0]  s1, s2;
	logic signed [RND_W-1:0]  prod_rnd;
	logic signed [ACC_W-1:0]  diff_w, hp_w, bp_w, lp_w, n1_w, n2_w, notch_w, resp_w;
	logic signed [ACC_W-1:0]  n1_wr, n2_wr, q1, q2;
	logic                     done1, done2;
	logic [STG_CNT_W-1:0]     stages_eff;
	logic signed [FIN_W-1:0]  fin3, fin_w;
	logic                     fin_fits;
	logic signed [SAMPLE_BITS-1:0] out_w;

	assign ch_sel = (CHANNELS > 1) ? CH_W'(channel_index) : '0;
	assign addr   = ADDR_W'(int'(stage_q) * CHANNELS + int'(ch_q));
	assign k_coef = K_W'({damping, 1'b0}) + K_W'(cutoff_gain);

	// a never-written entry reads as zero
	assign s1 = rdv_q ? rd1_q : '0;
	assign s2 = rdv_q ? rd2_q : '0;

	always_comb begin
		case (op)
			OP_MUL_KS1: begin
				coef_op = k_coef;
				sig_op  = s1;
			end
			OP_MUL_HD: begin
				coef_op = K_W'(normalizer);
				sig_op  = diff_q;
			end
			OP_MUL_GHP: begin
				coef_op = K_W'(cutoff_gain);
				sig_op  = hp_q;
			end
			OP_MUL_GBP: begin
				coef_op = K_W'(cutoff_gain);
				sig_op  = bp_q;
			end
			default: begin
				coef_op = '0;
				sig_op  = '0;
			end
		endcase
	end

	assign prod_rnd = round_coef(prod_q);
	assign diff_w   = sat_acc(SUM_W'(x_q) - SUM_W'(prod_rnd) - SUM_W'(s2));
	assign hp_w     = sat_acc(SUM_W'(prod_rnd));
	assign bp_w     = sat_acc(SUM_W'(prod_rnd) + SUM_W'(s1));
	assign lp_w     = sat_acc(SUM_W'(prod_rnd) + SUM_W'(s2));
	assign n1_w     = sat_acc(SUM_W'(ghp_q) + SUM_W'(bp_q));
	assign n2_w     = sat_acc(SUM_W'(gbp_q) + SUM_W'(lp_q));
	assign notch_w  = sat_acc(SUM_W'(lp_q) + SUM_W'(hp_q));

	always_comb begin
		case (response_type)
			RESP_LP:  resp_w = lp_q;
			RESP_BP:  resp_w = bp_q;
			RESP_HP:  resp_w = hp_q;
			default:  resp_w = notch_w;
		endcase
	end

	ctsvf_div #(.FRAC_W(FRAC_W)) u_div1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (op == OP_CLIP),
		.value  (n1_q),
		.done   (done1),
		.result (q1)
	);

	ctsvf_div #(.FRAC_W(FRAC_W)) u_div2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (op == OP_CLIP),
		.value  (n2_q),
		.done   (done2),
		.result (q2)
	);

	assign n1_wr = variant ? q1 : n1_q;
	assign n2_wr = variant ? q2 : n2_q;

	// output: optional 3/2 scale rounded half up, then clamp to sample width
	assign fin3     = FIN_W'(x_q) + (FIN_W'(x_q) <<< 1) + FIN_W'(1);
	assign fin_w    = variant ? (fin3 >>> 1) : FIN_W'(x_q);
	assign fin_fits = (&fin_w[FIN_W-1:SAMPLE_BITS-1]) || !(|fin_w[FIN_W-1:SAMPLE_BITS-1]);
	assign out_w    = fin_fits ? fin_w[SAMPLE_BITS-1:0] :
		(fin_w[FIN_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}});

	assign stages_eff = ({1'b0, stage_count} > STG_CNT_W'(MAX_STAGES)) ?
		STG_CNT_W'(MAX_STAGES) : {1'b0, stage_count};

	assign sts.no_stages  = (stage_count == '0);
	assign sts.last_stage = (STG_CNT_W'(stage_q) + STG_CNT_W'(1)) >= stages_eff;
	assign sts.clip_on    = variant;
	assign sts.div_done   = done1 && done2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= '0;
			vld_q   <= '0;
		end else if (op == OP_LOAD) begin
			stage_q <= '0;
		end else if (op == OP_WRITE) begin
			vld_q[addr] <= 1'b1;
			if (!sts.last_stage)
				stage_q <= stage_q + STG_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (op) inside
			OP_LOAD: begin
				x_q  <= ACC_W'(sample_in);
				ch_q <= ch_sel;
			end
			OP_READ: begin
				rd1_q <= mem1[addr];
				rd2_q <= mem2[addr];
				rdv_q <= vld_q[addr];
			end
			OP_MUL_KS1, OP_MUL_HD, OP_MUL_GHP: begin
				prod_q <= coef_mul(coef_op, sig_op);
			end
			OP_MUL_GBP: begin
				prod_q <= coef_mul(coef_op, sig_op);
				n1_q   <= n1_w;
			end
			OP_DIFF: diff_q <= diff_w;
			OP_HP:   hp_q   <= hp_w;
			OP_BP: begin
				ghp_q <= prod_rnd;
				bp_q  <= bp_w;
			end
			OP_LP: begin
				gbp_q <= prod_rnd;
				lp_q  <= lp_w;
			end
			OP_N2: begin
				n2_q <= n2_w;
				x_q  <= resp_w;
			end
			OP_WRITE: begin
				mem1[addr] <= n1_wr;
				mem2[addr] <= n2_wr;
			end
			OP_FINAL: out_q <= out_w;
			default: ;
		endcase
	end

	assign sample_out = out_q;

endmodule

// File: sv/ctsvf_ctrl.sv
// Controller: sequences one sample through the stages and drives the channel handshakes.
// Depends on ctsvf_pkg.
module ctsvf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  ctsvf_pkg::dp_sts_t sts,
	output ctsvf_pkg::dp_op_t  op
);
	import ctsvf_pkg::*;

	ctrl_state_t state_q, state_nxt;
	logic        out_valid_q;
	logic        final_go;

	// result register free, or being emptied this cycle
	assign final_go = !(out_valid_q && out_stall);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_nxt = sts.no_stages ? ST_FINAL : ST_READ;
			ST_READ:  state_nxt = ST_MKS;
			ST_MKS:   state_nxt = ST_DIFF;
			ST_DIFF:  state_nxt = ST_MHD;
			ST_MHD:   state_nxt = ST_HP;
			ST_HP:    state_nxt = ST_MGHP;
			ST_MGHP:  state_nxt = ST_BP;
			ST_BP:    state_nxt = ST_MGBP;
			ST_MGBP:  state_nxt = ST_LP;
			ST_LP:    state_nxt = ST_N2;
			ST_N2:    state_nxt = sts.clip_on ? ST_CLIP : ST_WRITE;
			ST_CLIP:  state_nxt = ST_DIVW;
			ST_DIVW:  if (sts.div_done) state_nxt = ST_WRITE;
			ST_WRITE: state_nxt = sts.last_stage ? ST_FINAL : ST_READ;
			ST_FINAL: if (final_go) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		op = OP_NONE;
		unique case (state_q)
			ST_IDLE:  if (in_valid) op = OP_LOAD;
			ST_READ:  op = OP_READ;
			ST_MKS:   op = OP_MUL_KS1;
			ST_DIFF:  op = OP_DIFF;
			ST_MHD:   op = OP_MUL_HD;
			ST_HP:    op = OP_HP;
			ST_MGHP:  op = OP_MUL_GHP;
			ST_BP:    op = OP_BP;
			ST_MGBP:  op = OP_MUL_GBP;
			ST_LP:    op = OP_LP;
			ST_N2:    op = OP_N2;
			ST_CLIP:  op = OP_CLIP;
			ST_DIVW:  op = OP_NONE;
			ST_WRITE: op = OP_WRITE;
			ST_FINAL: if (final_go) op = OP_FINAL;
			default:  op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_FINAL && final_go)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: sv/cascaded_tpt_state_variable_filter_top.sv
// Top level: APB register file, controller and datapath of the cascaded TPT SVF.
// Depends on ctsvf_pkg, ctsvf_ctrl, ctsvf_dp (and ctsvf_div below it).
//
// Input channel: in_valid/in_stall carry one beat of channel_index and sample_in.
// Output channel: out_valid/out_stall carry one beat of sample_out.
// Configuration goes through the APB port (byte address 4*index) while idle;
// the user must keep to this, as the block itself does not enforce it.
// Each sample runs through S = min(stage_count, MAX_STAGES) stages of one shared
// coefficient multiplier; with soft-clipped integrators each stage also waits
// for the two clip dividers, which retire one quotient bit per cycle. A new
// sample is accepted only once the block is back in idle, after the previous
// one has been written to the output register.
// A finished result waits in the output register; the next sample is accepted
// and processed meanwhile, and only its final write waits for the register.
// Reset returns the registers to their defaults and marks every integrator entry
// unwritten, so all integrators read as zero at once; no clearing pass is needed.
module cascaded_tpt_state_variable_filter_top #(
	parameter int MAX_STAGES  = 8,
	parameter int CHANNELS    = 2,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ctsvf_pkg::APB_AW-1:0]         paddr,
	input  logic [ctsvf_pkg::APB_DW-1:0]         pwdata,
	output logic [ctsvf_pkg::APB_DW-1:0]         prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 channel_index,
	input  logic signed [SAMPLE_BITS-1:0]        sample_in,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [SAMPLE_BITS-1:0]        sample_out
);
	import ctsvf_pkg::*;

	logic [G_W-1:0]  g_q;
	logic [R_W-1:0]  r_q;
	logic [H_W-1:0]  h_q;
	resp_t           resp_q;
	logic [SC_W-1:0] sc_q;
	logic            var_q;

	reg_idx_t reg_idx;
	logic     wr_en;
	dp_op_t   op;
	dp_sts_t  sts;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q    <= G_RESET;
			r_q    <= R_RESET;
			h_q    <= H_RESET;
			resp_q <= RESP_LP;
			sc_q   <= SC_RESET;
			var_q  <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CUTOFF:   g_q    <= pwdata[G_W-1:0];
				REG_DAMPING:  r_q    <= pwdata[R_W-1:0];
				REG_NORM:     h_q    <= pwdata[H_W-1:0];
				REG_RESPONSE: resp_q <= resp_t'(pwdata[1:0]);
				REG_STAGES:   sc_q   <= pwdata[SC_W-1:0];
				REG_VARIANT:  var_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CUTOFF:   prdata = APB_DW'(g_q);
			REG_DAMPING:  prdata = APB_DW'(r_q);
			REG_NORM:     prdata = APB_DW'(h_q);
			REG_RESPONSE: prdata = APB_DW'(resp_q);
			REG_STAGES:   prdata = APB_DW'(sc_q);
			REG_VARIANT:  prdata = APB_DW'(var_q);
			default:      prdata = '0;
		endcase
	end

	ctsvf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.op        (op)
	);

	ctsvf_dp #(
		.MAX_STAGES  (MAX_STAGES),
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.sts           (sts),
		.cutoff_gain   (g_q),
		.damping       (r_q),
		.normalizer    (h_q),
		.response_type (resp_q),
		.stage_count   (sc_q),
		.variant       (var_q),
		.channel_index (channel_index),
		.sample_in     (sample_in),
		.sample_out    (sample_out)
	);

endmodule

// File: sv/ctsvf_chk.sv
// Port-level checker for the cascaded TPT SVF top level, attached by bind.
// Depends on cascaded_tpt_state_variable_filter_top.
module ctsvf_chk #(
	parameter int SAMPLE_BITS = 24
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [SAMPLE_BITS-1:0] sample_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_out))
		else $error("stalled output beat changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after a beat");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared on the cycle after accept");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised while the block was idle");

endmodule

bind cascaded_tpt_state_variable_filter_top ctsvf_chk #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_ctsvf_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.sample_out (sample_out)
);

// File: test/testbench.sv
// Self-checking testbench for cascaded_tpt_state_variable_filter_top.
// Depends on ctsvf_pkg and the filter RTL; a scoreboard class predicts every output beat.
module testbench;
	import ctsvf_pkg::*;

	localparam int NUM_STAGES   = 8;
	localparam int NUM_CH       = 2;
	localparam int SW           = 24;
	localparam int ITEMS        = 1400;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int DRAIN_CYCLES = 400;

	// Bit-exact model of the filter cascade plus the queue of samples it owes us.
	class filter_scoreboard;
		logic [G_W-1:0]        gain;
		logic [R_W-1:0]        damp;
		logic [H_W-1:0]        norm;
		resp_t                 resp;
		logic [SC_W-1:0]       stages;
		bit                    clipped;
		longint                integ1[NUM_STAGES][NUM_CH];
		longint                integ2[NUM_STAGES][NUM_CH];
		logic signed [SW-1:0]  expected_out[$];
		int                    errors;

		function new();
			gain = G_RESET;
			damp = R_RESET;
			norm = H_RESET;
			resp = RESP_LP;
			stages = SC_RESET;
			clipped = 1'b0;
			errors = 0;
			foreach (integ1[s, c]) begin
				integ1[s][c] = 0;
				integ2[s][c] = 0;
			end
		endfunction

		function void set_reg(reg_idx_t idx, logic [APB_DW-1:0] v);
			case (idx)
				REG_CUTOFF:   gain = v[G_W-1:0];
				REG_DAMPING:  damp = v[R_W-1:0];
				REG_NORM:     norm = v[H_W-1:0];
				REG_RESPONSE: resp = resp_t'(v[1:0]);
				REG_STAGES:   stages = v[SC_W-1:0];
				REG_VARIANT:  clipped = v[0];
				default: ;
			endcase
		endfunction

		function longint saturate(longint v, int bits);
			longint hi;
			hi = (64'sd1 <<< (bits - 1)) - 1;
			if (v > hi)
				return hi;
			if (v < -hi - 1)
				return -hi - 1;
			return v;
		endfunction

		// coefficient product, >> 20 rounding half up
		function longint scale_coef(longint coef, longint sig);
			return (coef * sig + 64'sd524288) >>> COEF_SHIFT;
		endfunction

		function longint compress(longint v);
			longint unity;
			longint mag;
			unity = 64'sd1 <<< (SW - 1);
			mag = (v < 0) ? -v : v;
			return (v * unity) / (unity + (mag * 5) / 2);
		endfunction

		function logic signed [SW-1:0] filter_sample(bit ch, logic signed [SW-1:0] smp);
			longint x, g, d, k, h, s1, s2, diff, hp, ghp, bp, gbp, lp, n1, n2;
			int depth;
			int s;
			x = smp;
			g = gain;
			d = damp;
			k = 2 * d + g;
			h = norm;
			depth = (stages > NUM_STAGES) ? NUM_STAGES : stages;
			for (s = 0; s < depth; s++) begin
				s1 = integ1[s][ch];
				s2 = integ2[s][ch];
				diff = saturate(x - scale_coef(k, s1) - s2, ACC_W);
				hp = saturate(scale_coef(h, diff), ACC_W);
				ghp = scale_coef(g, hp);
				bp = saturate(ghp + s1, ACC_W);
				gbp = scale_coef(g, bp);
				lp = saturate(gbp + s2, ACC_W);
				n1 = saturate(ghp + bp, ACC_W);
				n2 = saturate(gbp + lp, ACC_W);
				if (clipped) begin
					n1 = compress(n1);
					n2 = compress(n2);
				end
				integ1[s][ch] = n1;
				integ2[s][ch] = n2;
				case (resp)
					RESP_LP: x = lp;
					RESP_BP: x = bp;
					RESP_HP: x = hp;
					default: x = saturate(lp + hp, ACC_W);
				endcase
			end
			if (clipped)
				x = (3 * x + 1) >>> 1;
			x = saturate(x, SW);
			return x[SW-1:0];
		endfunction

		function void note_sample(bit ch, logic signed [SW-1:0] smp);
			expected_out.push_back(filter_sample(ch, smp));
		endfunction

		function int pending();
			return expected_out.size();
		endfunction

		function void check_sample(logic signed [SW-1:0] got);
			logic signed [SW-1:0] want;
			if (expected_out.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("sample_out beat %0d with nothing pending", got);
				return;
			end
			want = expected_out.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("sample_out mismatch: expected %0d, got %0d", want, got);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [APB_AW-1:0]    paddr;
	logic [APB_DW-1:0]    pwdata;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;
	logic                 in_valid;
	logic                 in_stall;
	logic                 channel_index;
	logic signed [SW-1:0] sample_in;
	logic                 out_valid;
	logic                 out_stall;
	logic signed [SW-1:0] sample_out;

	bit               calm = 1'b0;
	int               sent = 0;
	longint           cycles = 0;
	filter_scoreboard sb;

	cascaded_tpt_state_variable_filter_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.channel_index (channel_index),
		.sample_in     (sample_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sample_out    (sample_out)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT)
			@(posedge clk) cycles++;
		$display("cascaded_tpt_state_variable_filter_top verification failed");
		$finish;
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= !calm && ($urandom_range(99) < 22);
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_sample(sample_out);
		end
	end

	// h = 1/(1 + 2Rg + g^2) in Q1.20 for g, R in Q4.20
	function automatic logic [31:0] norm_for(input logic [31:0] g, input logic [31:0] r);
		longint gl, rl, den;
		gl = g[G_W-1:0];
		rl = r[R_W-1:0];
		den = (64'sd1 <<< 40) + 2 * rl * gl + gl * gl;
		return 32'((64'sd1 <<< 60) / den);
	endfunction

	// called and returns at a falling edge
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, v);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain_wait();
		while (sb.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic configure(input logic [31:0] g, r, h, rt, st, vr);
		// drop the last beat so the idle block does not take it again
		in_valid <= 1'b0;
		drain_wait();
		write_reg(REG_CUTOFF, g);
		write_reg(REG_DAMPING, r);
		write_reg(REG_NORM, h);
		write_reg(REG_RESPONSE, rt);
		write_reg(REG_STAGES, st);
		write_reg(REG_VARIANT, vr);
	endtask

	// one input beat; called and returns at a falling edge
	task automatic send_sample(input logic ch, input logic signed [SW-1:0] x);
		while (!calm && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		channel_index <= ch;
		sample_in <= x;
		do @(posedge clk); while (in_stall);
		sb.note_sample(ch, x);
		sent++;
		@(negedge clk);
	endtask

	task automatic random_phase(input bit quiet);
		logic [31:0] g, r, h, st;
		logic signed [SW-1:0] x;
		int n;
		int i;
		case ($urandom_range(9))
			0: g = $urandom_range(0, 24'hFFFFFF);
			1: g = 0;
			default: g = $urandom_range(1, 1 << 21);
		endcase
		case ($urandom_range(9))
			0: r = $urandom_range(0, 24'hFFFFFF);
			1: r = 0;
			default: r = $urandom_range(1 << 16, 1 << 21);
		endcase
		h = ($urandom_range(9) < 8) ? norm_for(g, r) : $urandom_range(0, 21'h1FFFFF);
		// mostly short cascades; deep ones are slow when clipped
		case ($urandom_range(19))
			0: st = 0;
			1: st = $urandom_range(9, 15);
			2, 3: st = $urandom_range(5, 8);
			4, 5, 6, 7: st = $urandom_range(3, 4);
			default: st = $urandom_range(1, 2);
		endcase
		// junk above each register's width must be ignored
		configure(g | ($urandom << G_W), r | ($urandom << R_W), h | ($urandom << H_W),
			$urandom, st | ($urandom << SC_W), $urandom);
		calm <= quiet;
		n = $urandom_range(20, 150);
		x = '0;
		for (i = 0; i < n && sent < ITEMS; i++) begin
			case ($urandom_range(9))
				6, 7: x = SW'($urandom_range(0, 1 << 17) - (1 << 16));
				8: x = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
				9: ;  // hold previous value: step input
				default: x = SW'($urandom);
			endcase
			send_sample(1'($urandom_range(1)), x);
		end
	endtask

	initial begin
		int phase;
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		channel_index = 1'b0;
		sample_in = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: single lowpass stage
		send_sample(1'b0, 24'sh7FFFFF);
		send_sample(1'b1, 24'sh800000);
		send_sample(1'b0, 24'sd0);
		send_sample(1'b1, -24'sd1);
		send_sample(1'b0, 24'sd1);
		// no stages, clipped: pass-through with 1.5 scale and clamp
		configure(G_RESET, R_RESET, H_RESET, RESP_BP, 0, 1);
		send_sample(1'b0, 24'sh7FFFFF);
		send_sample(1'b1, 24'sh800000);
		send_sample(1'b1, 24'sh400000);
		// stage count over the maximum, max gain, zero damping, h above 1.0
		configure(24'hFFFFFF, 0, 21'h1FFFFF, RESP_HP, 15, 0);
		send_sample(1'b0, 24'sh7FFFFF);
		send_sample(1'b1, 24'sh800000);
		send_sample(1'b0, 24'sh800000);
		send_sample(1'b1, 24'sh7FFFFF);
		configure(0, 24'hFFFFFF, 0, RESP_NOTCH, 8, 1);
		send_sample(1'b0, 24'sh7FFFFF);
		send_sample(1'b1, 24'sh800000);
		send_sample(1'b0, 24'sh123456);
		send_sample(1'b1, -24'sh123456);
		configure(24'h040000, 24'h0B504F, norm_for(24'h040000, 24'h0B504F), RESP_LP, 3, 1);
		send_sample(1'b0, 24'sh7FFFFF);
		send_sample(1'b0, 24'sh7FFFFF);
		send_sample(1'b1, 24'sh800000);
		send_sample(1'b1, 24'sd0);

		phase = 0;
		while (sent < ITEMS) begin
			random_phase(phase == 3);
			phase++;
		end
		in_valid <= 1'b0;
		calm <= 1'b0;
		drain_wait();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			$display("%0d expected sample_out beats never arrived", sb.pending());
		if (sb.errors == 0 && sb.pending() == 0)
			$display("cascaded_tpt_state_variable_filter_top verification clean");
		else
			$display("cascaded_tpt_state_variable_filter_top verification failed");
		$finish;
	end

endmodule
